@@ hw/rtl/hed_pkg.sv @@
// ----------------------------------------------------------------------------
// HTML entity decoder package
// Shared types, character codes and the entity lookup used by the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hed_pkg;

   // Number of bytes an open unit may hold before it is flushed.
   localparam int UnitDepth = 6;
   // Longest burst that one request can produce.
   localparam int BurstMax  = UnitDepth + 1;
   // Number of known entities.
   localparam int EntCount  = 6;
   // Command queue depth; must be a power of two.
   localparam int QueueDepth = 4;
   localparam int QPtrW      = $clog2(QueueDepth);

   localparam logic [7:0] CH_AMP  = 8'h26;
   localparam logic [7:0] CH_SEMI = 8'h3B;

   // Entity text without the closing semicolon, its length and its character.
   localparam logic [7:0] ENT_TEXT [EntCount][UnitDepth] = '{
      '{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h00},   // &quot
      '{8'h26, 8'h61, 8'h70, 8'h6F, 8'h73, 8'h00},   // &apos
      '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h00, 8'h00},   // &amp
      '{8'h26, 8'h67, 8'h74, 8'h00, 8'h00, 8'h00},   // &gt
      '{8'h26, 8'h6C, 8'h74, 8'h00, 8'h00, 8'h00},   // &lt
      '{8'h26, 8'h66, 8'h72, 8'h61, 8'h73, 8'h6C}    // &frasl
   };
   localparam logic [2:0] ENT_LEN  [EntCount] = '{3'd5, 3'd5, 3'd4, 3'd3, 3'd3, 3'd6};
   localparam logic [7:0] ENT_CODE [EntCount] = '{8'h22, 8'h27, 8'h26, 8'h3E, 8'h3C, 8'h2F};

   // One burst of output bytes, handed from the front end to the emitter.
   typedef struct packed {
      logic                   last;
      logic [2:0]             count;
      logic [BurstMax-1:0][7:0] bytes;
   } hed_cmd_type;

   typedef struct packed {
      logic       hit;
      logic [7:0] code;
   } hed_match_type;

   // Compares the held bytes against every entity of the same length.
   function automatic hed_match_type entity_lookup(
      input logic [UnitDepth-1:0][7:0] held,
      input logic [2:0]                held_cnt
   );
      hed_match_type res;
      logic          ok;
      res.hit  = 1'b0;
      res.code = '0;
      for (int e = 0; e < EntCount; e++) begin
         ok = (ENT_LEN[e] == held_cnt);
         for (int i = 0; i < UnitDepth; i++) begin
            if ((3'(i) < ENT_LEN[e]) && (held[i] != ENT_TEXT[e][i])) begin
               ok = 1'b0;
            end
         end
         if (ok && !res.hit) begin
            res.hit  = 1'b1;
            res.code = ENT_CODE[e];
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/hed_front.sv @@
// ----------------------------------------------------------------------------
// HTML entity decoder front end
// Accepts input bytes, tracks open units and queues output bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hed_front
   import hed_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // char_in
   input  wire logic        req_tlast,    // last_in
   output logic             push,
   output hed_cmd_type      cmd,
   input  wire logic        full
);

   typedef enum logic [1:0] {
      MODE_PLAIN,
      MODE_HOLD,
      MODE_SKIP
   } mode_type;

   mode_type                  mode_ff, mode_in;
   logic [2:0]                cnt_ff, cnt_in;
   logic [7:0]                held_ff [UnitDepth];
   logic [UnitDepth-1:0][7:0] held_vec;
   logic                      accept;
   logic                      wr_en;
   logic [2:0]                wr_idx;
   logic [BurstMax-1:0][7:0]  flush_bytes;
   hed_match_type             match;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   // Held bytes with the incoming byte placed right after them.
   always_comb begin
      for (int i = 0; i < UnitDepth; i++) begin
         held_vec[i]    = held_ff[i];
         flush_bytes[i] = (3'(i) == cnt_ff) ? req_tdata : held_ff[i];
      end
      flush_bytes[BurstMax-1] = req_tdata;
   end

   assign match = entity_lookup(held_vec, cnt_ff);

   // Request classification and next-state logic.
   always_comb begin
      mode_in   = mode_ff;
      cnt_in    = cnt_ff;
      wr_en     = 1'b0;
      wr_idx    = cnt_ff;
      push      = 1'b0;
      cmd.last  = req_tlast;
      cmd.count = 3'd1;
      cmd.bytes = '0;
      cmd.bytes[0] = req_tdata;
      if (accept) begin
         case (mode_ff)
            MODE_HOLD: begin
               if (req_tdata == CH_SEMI) begin
                  push = 1'b1;
                  if (match.hit) begin
                     cmd.bytes[0] = match.code;
                  end else begin
                     cmd.bytes = flush_bytes;
                     cmd.count = cnt_ff + 3'd1;
                  end
                  mode_in = MODE_PLAIN;
                  cnt_in  = 3'd0;
               end else if (cnt_ff < 3'(UnitDepth)) begin
                  wr_en  = 1'b1;
                  cnt_in = cnt_ff + 3'd1;
                  if (req_tlast) begin
                     push      = 1'b1;
                     cmd.bytes = flush_bytes;
                     cmd.count = cnt_ff + 3'd1;
                     mode_in   = MODE_PLAIN;
                     cnt_in    = 3'd0;
                  end
               end else begin
                  // Overlong unit: flush everything and pass the rest through.
                  push      = 1'b1;
                  cmd.bytes = flush_bytes;
                  cmd.count = 3'(BurstMax);
                  mode_in   = req_tlast ? MODE_PLAIN : MODE_SKIP;
                  cnt_in    = 3'd0;
               end
            end
            MODE_SKIP: begin
               push = 1'b1;
               if ((req_tdata == CH_SEMI) || req_tlast) begin
                  mode_in = MODE_PLAIN;
               end
            end
            default: begin
               mode_in = MODE_PLAIN;
               if ((req_tdata == CH_AMP) && !req_tlast) begin
                  wr_en   = 1'b1;
                  wr_idx  = 3'd0;
                  cnt_in  = 3'd1;
                  mode_in = MODE_HOLD;
               end else begin
                  push = 1'b1;
               end
            end
         endcase
      end
   end

   // State and held bytes.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PLAIN;
         cnt_ff  <= 3'd0;
      end else begin
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
      end
      if (wr_en) begin
         held_ff[wr_idx] <= req_tdata;
      end
   end

`ifndef SYNTHESIS
   a_hold_count: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_HOLD) |-> (cnt_ff != 3'd0 && cnt_ff <= 3'(UnitDepth)))
      else $error("held count out of range while a unit is open");
   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != MODE_HOLD) |-> (cnt_ff == 3'd0))
      else $error("held count not clear outside an open unit");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/hed_queue.sv @@
// ----------------------------------------------------------------------------
// HTML entity decoder command queue
// Small register FIFO of output bursts between front end and emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hed_queue
   import hed_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire hed_cmd_type  push_cmd,
   output logic              full,
   input  wire logic         pop,
   output hed_cmd_type       head_cmd,
   output logic              empty
);

   hed_cmd_type       mem_ff [QueueDepth];
   logic [QPtrW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QPtrW:0]    fill_ff;
   logic              do_push, do_pop;

   assign full     = (fill_ff == (QPtrW + 1)'(QueueDepth));
   assign empty    = (fill_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = mem_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef SYNTHESIS
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= (QPtrW + 1)'(QueueDepth))
      else $error("queue fill count beyond depth");
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("burst pushed into a full queue");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/hed_emit.sv @@
// ----------------------------------------------------------------------------
// HTML entity decoder emitter
// Pops bursts from the queue and sends them out one byte per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hed_emit
   import hed_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire hed_cmd_type  head_cmd,
   input  wire logic         empty,
   output logic              pop,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [7:0]        rsp_tdata,    // char_out
   output logic              rsp_tlast     // last_out
);

   logic [BurstMax-1:0][7:0] bytes_ff;
   logic [2:0]               rem_ff;
   logic                     last_ff;
   logic                     busy_ff;
   logic                     take;
   logic                     free;

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = bytes_ff[0];
   assign rsp_tlast  = last_ff && (rem_ff == 3'd1);

   assign take = busy_ff && rsp_tready;
   assign free = !busy_ff || (take && rem_ff == 3'd1);
   assign pop  = free && !empty;

   // Burst register: load a new burst or shift out the byte just taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rem_ff  <= 3'd0;
      end else if (pop) begin
         busy_ff <= 1'b1;
         rem_ff  <= head_cmd.count;
      end else if (take) begin
         busy_ff <= (rem_ff != 3'd1);
         rem_ff  <= rem_ff - 3'd1;
      end
      if (pop) begin
         bytes_ff <= head_cmd.bytes;
         last_ff  <= head_cmd.last;
      end else if (take) begin
         bytes_ff <= {8'h00, bytes_ff[BurstMax-1:1]};
      end
   end

`ifndef SYNTHESIS
   a_busy_rem: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_ff != 3'd0 && rem_ff <= 3'(BurstMax)))
      else $error("emitter busy with no bytes left");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/html_entity_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// HTML entity decoder unit
// Decodes &quot; &apos; &amp; &gt; &lt; &frasl; in a byte stream.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ stream, one text byte each, with req_tlast on
// the final byte of a text. Decoded bytes leave on the rsp_ stream, with
// rsp_tlast on the final byte produced for a request that carried req_tlast.
// A request can yield no byte (held inside an open unit), one byte, or a
// burst of up to seven bytes when a unit is flushed.
// Requests are taken one per cycle while the four-entry burst queue has room.
// With the queue and the emitter idle, an accepted request's burst is written
// into the queue and then loaded into the emitter's burst register, where
// rsp_tvalid rises; otherwise it waits behind the bytes already queued. The
// output side sends one byte per cycle while rsp_tready is high, so the
// emitter's single output port sets the sustained rate during flush bursts.
// A stalled receiver holds the current byte; the queue fills and then
// req_tready drops until space frees up.
// Synchronous reset returns the decoder to plain passthrough, empties the
// queue and drops rsp_tvalid; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module html_entity_decoder_unit
   import hed_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // char_in
   input  wire logic        req_tlast,    // last_in
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,    // char_out
   output logic             rsp_tlast     // last_out
);

   logic        push;
   logic        full;
   logic        pop;
   logic        empty;
   hed_cmd_type push_cmd;
   hed_cmd_type head_cmd;

   // Front end: classifies each request and builds output bursts.
   hed_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push       (push),
      .cmd        (push_cmd),
      .full       (full)
   );

   // Burst queue between the two halves.
   hed_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (full),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (empty)
   );

   // Back end: serializes bursts onto the output stream.
   hed_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .empty      (empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
